### src/alq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alq_pkg
// Shared types and constants of the audio level quantizer.
// ----------------------------------------------------------------------------
package alq_pkg;

    localparam int LEVEL_W = 12;
    localparam int CODE_W  = 8;
    localparam int STEP_W  = 7;
    localparam int HOLD_W  = 16;

    localparam int DEF_BLOCK_LENGTH = 16;
    localparam int DEF_MAX_STEPS    = 64;

    localparam logic signed [CODE_W-1:0] CODE_MAX = 8'sd127;
    localparam logic signed [CODE_W-1:0] CODE_MIN = -8'sd127;

    localparam logic [2:0] REG_STEP_COUNT = 3'd0;
    localparam logic [2:0] REG_NOISE      = 3'd1;
    localparam logic [2:0] REG_FULL       = 3'd2;
    localparam logic [2:0] REG_HOLD       = 3'd3;
    localparam logic [2:0] REG_MUTE       = 3'd4;
    localparam logic [2:0] REG_QUASI      = 3'd5;

    typedef struct packed {
        logic [STEP_W-1:0]        step_count;
        logic [LEVEL_W-1:0]       noise_floor;
        logic [LEVEL_W-1:0]       full_scale;
        logic [HOLD_W-1:0]        mute_hold;
        logic signed [CODE_W-1:0] mute_code;
        logic signed [CODE_W-1:0] quasi_mute_code;
    } cfg_t;

    typedef struct packed {
        logic                     graded;
        logic [LEVEL_W-1:0]       level;
        logic signed [CODE_W-1:0] code;
    } cmd_t;

    function automatic logic signed [CODE_W-1:0] sat_code(input logic signed [CODE_W-1:0] c);
        return (c < CODE_MIN) ? CODE_MIN : c;
    endfunction

endpackage
`default_nettype wire

### src/alq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alq_front
// Accepts level words, tracks silence and classifies each word as a fixed
// mute code or a graded step to be searched.
// ----------------------------------------------------------------------------
module alq_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire alq_pkg::cfg_t               cfg,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,
    output logic                             push,
    output alq_pkg::cmd_t                    push_cmd,
    input  wire logic                        full
);
    import alq_pkg::*;

    logic [HOLD_W-1:0]  silence_count_reg;
    logic [HOLD_W-1:0]  silence_count_next;
    logic [LEVEL_W-1:0] level;
    logic               accept;

    assign level    = s_tdata[LEVEL_W-1:0];
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    always_comb
    begin
        silence_count_next = silence_count_reg;
        push_cmd.level     = level;
        push_cmd.graded    = 1'b0;
        push_cmd.code      = sat_code(cfg.quasi_mute_code);
        if (level < cfg.noise_floor)
        begin
            if (silence_count_reg > cfg.mute_hold)
            begin
                push_cmd.code = sat_code(cfg.mute_code);
            end
            else if (silence_count_reg != {HOLD_W{1'b1}})
            begin
                silence_count_next = silence_count_reg + 1'b1;
            end
        end
        else
        begin
            silence_count_next = '0;
            push_cmd.graded    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_count_reg <= '0;
        end
        else if (accept)
        begin
            silence_count_reg <= silence_count_next;
        end
    end

endmodule
`default_nettype wire

### src/alq_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alq_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module alq_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire alq_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output alq_pkg::cmd_t      pop_cmd
);
    import alq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

### src/alq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alq_back
// Runs the threshold search on graded words, stores the code in block memory,
// scans it for max, min and sum, divides for the average and drives results.
// ----------------------------------------------------------------------------
module alq_back
#(
    parameter int BLOCK_LENGTH = alq_pkg::DEF_BLOCK_LENGTH,
    parameter int MAX_STEPS    = alq_pkg::DEF_MAX_STEPS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire alq_pkg::cfg_t cfg,
    input  wire logic          not_empty,
    input  wire alq_pkg::cmd_t pop_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast
);
    import alq_pkg::*;

    localparam int AW     = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
    localparam int CW     = $clog2(BLOCK_LENGTH + 1);
    localparam int SUM_W  = $clog2(BLOCK_LENGTH * 127 + 1) + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int SQ_W   = 14;
    localparam int PR_W   = LEVEL_W + SQ_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_LDEN, ST_MUL, ST_CMP, ST_WR, ST_RD, ST_ACC,
        ST_DIVS, ST_DIV, ST_FIN
    } state_t;

    state_t                    state_reg;
    cmd_t                      cmd_reg;
    logic [STEP_W-1:0]         s_reg;
    logic [LEVEL_W-1:0]        diff_reg;
    logic signed [8:0]         i_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W-1:0]           den_reg;
    logic [PR_W-1:0]           lden_reg;
    logic [PR_W-1:0]           prod_reg;
    logic signed [CODE_W-1:0]  code_reg;
    logic signed [CODE_W-1:0]  mem [BLOCK_LENGTH];
    logic signed [CODE_W-1:0]  rd_data_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             n_reg;
    logic [CW-1:0]             k_reg;
    logic signed [CODE_W-1:0]  mx_reg;
    logic signed [CODE_W-1:0]  mn_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          mag_reg;
    logic [SUM_W-1:0]          quot_reg;
    logic [CW:0]               rem_reg;
    logic [CW:0]               rem_try;
    logic                      neg_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic [STEP_W-1:0]         s_clamp;
    logic [STEP_W-1:0]         s_m1;
    logic signed [8:0]         qp1;
    logic signed [17:0]        qp1_sq;
    logic [15:0]               sq_next;
    logic signed [8:0]         s_ext;
    logic signed [8:0]         i_inc;
    logic signed [SUM_W-1:0]   quot_signed;
    logic                      out_load;

    always_comb
    begin
        if (cfg.step_count < STEP_W'(2))
        begin
            s_clamp = STEP_W'(2);
        end
        else if (cfg.step_count > STEP_W'(MAX_STEPS))
        begin
            s_clamp = STEP_W'(MAX_STEPS);
        end
        else
        begin
            s_clamp = cfg.step_count;
        end
    end

    assign s_m1        = s_clamp - STEP_W'(1);
    assign qp1         = 9'(cfg.quasi_mute_code) + 9'sd1;
    assign qp1_sq      = qp1 * qp1;
    assign sq_next     = {2'b00, sq_reg} + {{6{i_reg[8]}}, i_reg, 1'b0} + 16'd1;
    assign s_ext       = $signed({2'b00, s_reg});
    assign i_inc       = i_reg + 9'sd1;
    assign sum_next    = sum_reg + {{(SUM_W-CODE_W){rd_data_reg[CODE_W-1]}}, rd_data_reg};
    assign rem_try     = {rem_reg[CW-1:0], mag_reg[SUM_W-1]};
    assign quot_signed = neg_reg ? -$signed(quot_reg) : $signed(quot_reg);
    assign pop         = (state_reg == ST_IDLE) && not_empty;
    assign out_load    = (state_reg == ST_FIN) && (!m_tvalid || m_tready);

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[k_reg[AW-1:0]];
        if (state_reg == ST_WR)
        begin
            mem[fill_reg[AW-1:0]] <= code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
            m_tlast   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (not_empty)
                    begin
                        cmd_reg  <= pop_cmd;
                        code_reg <= pop_cmd.code;
                        state_reg <= pop_cmd.graded ? ST_PREP : ST_WR;
                    end
                end
                ST_PREP:
                begin
                    s_reg    <= s_clamp;
                    diff_reg <= (cfg.full_scale >= cfg.noise_floor) ?
                                (cfg.full_scale - cfg.noise_floor) : '0;
                    i_reg    <= qp1;
                    sq_reg   <= qp1_sq[SQ_W-1:0];
                    den_reg  <= SQ_W'(s_m1 * s_m1);
                    state_reg <= ST_LDEN;
                end
                ST_LDEN:
                begin
                    lden_reg <= (cmd_reg.level - cfg.noise_floor) * den_reg;
                    if (i_reg >= s_ext)
                    begin
                        code_reg  <= CODE_W'(s_reg - STEP_W'(1));
                        state_reg <= ST_WR;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= diff_reg * sq_reg;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (lden_reg <= prod_reg)
                    begin
                        code_reg  <= i_reg[CODE_W-1:0];
                        state_reg <= ST_WR;
                    end
                    else if (i_inc >= s_ext)
                    begin
                        code_reg  <= CODE_W'(s_reg - STEP_W'(1));
                        state_reg <= ST_WR;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        sq_reg    <= sq_next[SQ_W-1:0];
                        state_reg <= ST_MUL;
                    end
                end
                ST_WR:
                begin
                    n_reg     <= fill_reg + CW'(1);
                    k_reg     <= '0;
                    mx_reg    <= CODE_MIN;
                    mn_reg    <= CODE_MAX;
                    sum_reg   <= '0;
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (rd_data_reg > mx_reg)
                    begin
                        mx_reg <= rd_data_reg;
                    end
                    if (rd_data_reg < mn_reg)
                    begin
                        mn_reg <= rd_data_reg;
                    end
                    sum_reg   <= sum_next;
                    k_reg     <= k_reg + CW'(1);
                    state_reg <= (k_reg + CW'(1) == n_reg) ? ST_DIVS : ST_RD;
                end
                ST_DIVS:
                begin
                    neg_reg   <= sum_reg[SUM_W-1];
                    mag_reg   <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    dcnt_reg  <= DCNT_W'(SUM_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (rem_try >= {1'b0, n_reg})
                    begin
                        rem_reg  <= rem_try - {1'b0, n_reg};
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_try;
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
                    end
                    mag_reg  <= {mag_reg[SUM_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        m_tdata   <= {quot_signed[CODE_W-1:0], mn_reg, mx_reg, code_reg};
                        m_tlast   <= (n_reg == CW'(BLOCK_LENGTH));
                        fill_reg  <= (n_reg == CW'(BLOCK_LENGTH)) ? '0 : n_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (i_reg < s_ext))
        else $error("search index past top step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (n_reg != '0 && n_reg <= CW'(BLOCK_LENGTH)
                                   && k_reg < n_reg))
        else $error("block scan out of range");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (quot_reg <= SUM_W'(127)))
        else $error("average magnitude out of range");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < CW'(BLOCK_LENGTH)))
        else $error("fill count past block length");

endmodule
`default_nettype wire

### src/audio_level_quantizer_with_mute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_level_quantizer_with_mute
// Maps averaged ADC levels to volume step codes with mute hold and reports a
// running max, min and average over a block of codes.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   s_tdata[11:0] ad_level
//   m_*       out  m_tvalid/m_tready   m_tdata step,max,min,average; m_tlast end
//   APB       in   psel/penable/pready six registers at 4*index
//
// A graded word runs the threshold search: setup in ST_PREP and ST_LDEN, then
// a multiply (ST_MUL) and compare (ST_CMP) per searched step. Every word then
// goes through the block scan and the average divide over the stored codes.
// Reset clears the silence count, the fill count and the output. The front
// accepts words into a two-entry queue while the back end or output stalls.
// ----------------------------------------------------------------------------
module audio_level_quantizer_with_mute
#(
    parameter int BLOCK_LENGTH = alq_pkg::DEF_BLOCK_LENGTH,
    parameter int MAX_STEPS    = alq_pkg::DEF_MAX_STEPS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] ad_level
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // step_code, block_max, block_min, block_average
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import alq_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       push_cmd;
    cmd_t       pop_cmd;
    logic       push;
    logic       pop;
    logic       full;
    logic       not_empty;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_count      <= STEP_W'(16);
            cfg_reg.noise_floor     <= LEVEL_W'(100);
            cfg_reg.full_scale      <= LEVEL_W'(4095);
            cfg_reg.mute_hold       <= HOLD_W'(1000);
            cfg_reg.mute_code       <= 8'sd0;
            cfg_reg.quasi_mute_code <= 8'sd1;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_STEP_COUNT: cfg_reg.step_count      <= pwdata[STEP_W-1:0];
                REG_NOISE:      cfg_reg.noise_floor     <= pwdata[LEVEL_W-1:0];
                REG_FULL:       cfg_reg.full_scale      <= pwdata[LEVEL_W-1:0];
                REG_HOLD:       cfg_reg.mute_hold       <= pwdata[HOLD_W-1:0];
                REG_MUTE:       cfg_reg.mute_code       <= pwdata[CODE_W-1:0];
                REG_QUASI:      cfg_reg.quasi_mute_code <= pwdata[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_STEP_COUNT: prdata = 32'(cfg_reg.step_count);
            REG_NOISE:      prdata = 32'(cfg_reg.noise_floor);
            REG_FULL:       prdata = 32'(cfg_reg.full_scale);
            REG_HOLD:       prdata = 32'(cfg_reg.mute_hold);
            REG_MUTE:       prdata = {{24{cfg_reg.mute_code[7]}}, cfg_reg.mute_code};
            REG_QUASI:      prdata = {{24{cfg_reg.quasi_mute_code[7]}}, cfg_reg.quasi_mute_code};
            default:        prdata = '0;
        endcase
    end

    alq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    alq_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_cmd   (pop_cmd)
    );

    alq_back
    #(
        .BLOCK_LENGTH (BLOCK_LENGTH),
        .MAX_STEPS    (MAX_STEPS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .not_empty (not_empty),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
